// File: hdl/tebac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tebac_pkg;

    // access result codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BOUNDS   = 2'd1;
    localparam logic [1:0] STATUS_READONLY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BUFFER_SIZE = 2'd0;
    localparam logic [1:0] CFG_READ_ONLY   = 2'd1;

    localparam logic [16:0] RESET_SIZE = 17'(64 * 1024);

    localparam logic [0:0] REQ_READ  = 1'b0;
    localparam logic [0:0] REQ_WRITE = 1'b1;

    // size code: 0 one byte, 1 two, 2 four, 3 eight
    typedef struct packed {
        logic       known;
        logic [1:0] size;
        logic       sgn;
        logic       little;
    } kind_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WORK,
        S_FINISH
    } state_t;

    function automatic kind_t decode_type(input logic [4:0] code);
        kind_t k;
        k = '{known: 1'b1, size: 2'd0, sgn: 1'b0, little: 1'b0};
        case (code)
            5'd0:  k = '{1'b1, 2'd0, 1'b0, 1'b0};
            5'd1:  k = '{1'b1, 2'd0, 1'b1, 1'b0};
            5'd2:  k = '{1'b1, 2'd1, 1'b0, 1'b1};
            5'd3:  k = '{1'b1, 2'd1, 1'b0, 1'b0};
            5'd4:  k = '{1'b1, 2'd1, 1'b1, 1'b1};
            5'd5:  k = '{1'b1, 2'd1, 1'b1, 1'b0};
            5'd6:  k = '{1'b1, 2'd2, 1'b0, 1'b1};
            5'd7:  k = '{1'b1, 2'd2, 1'b0, 1'b0};
            5'd8:  k = '{1'b1, 2'd2, 1'b1, 1'b1};
            5'd9:  k = '{1'b1, 2'd2, 1'b1, 1'b0};
            5'd10: k = '{1'b1, 2'd3, 1'b0, 1'b1};
            5'd11: k = '{1'b1, 2'd3, 1'b0, 1'b0};
            5'd12: k = '{1'b1, 2'd3, 1'b1, 1'b1};
            5'd13: k = '{1'b1, 2'd3, 1'b1, 1'b0};
            5'd14: k = '{1'b1, 2'd2, 1'b0, 1'b1};
            5'd15: k = '{1'b1, 2'd2, 1'b0, 1'b0};
            5'd16: k = '{1'b1, 2'd3, 1'b0, 1'b1};
            5'd17: k = '{1'b1, 2'd3, 1'b0, 1'b0};
            default: k = '{1'b0, 2'd0, 1'b0, 1'b0};
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tebac_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tebac_store #(
    parameter int unsigned DEPTH  = 65536,
    parameter int unsigned ADDR_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [7:0]        wr_data,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/typed_endian_buffer_access_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Direction
// input     s_valid/s_ready, s_req_type,            in
//           s_type_code, s_byte_offset, s_write_value
// result    m_valid/m_ready, m_read_value,          out
//           m_status, m_next_offset
// config    cfg_wr_en, cfg_index, cfg_wr_data       in
//
// Byte-serial store port, one memory byte per cycle: an access of n bytes steps
// through S_WORK, a byte at a time, then loads the result register in S_FINISH;
// a failed access goes from S_IDLE straight to S_FINISH. s_ready is high only in
// S_IDLE. After reset the store is swept to zero, one byte per cycle, with s_ready
// low; config writes are taken during the sweep.
// A held result only stalls the next item at its last step; the next input
// transfer is still taken while the result waits.

module typed_endian_buffer_access_core
    import tebac_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [0:0]  s_req_type,
    input  wire logic [4:0]  s_type_code,
    input  wire logic [15:0] s_byte_offset,
    input  wire logic [63:0] s_write_value,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_read_value,
    output logic      [1:0]  m_status,
    output logic      [16:0] m_next_offset,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_wr_data
);

    localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
    localparam int unsigned LIMIT  = (BUFFER_BYTES > 131071) ? 131071 : BUFFER_BYTES;
    localparam logic [16:0] LIMIT17 = 17'(LIMIT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_BYTES - 1);

    // configuration
    logic [16:0] cfg_size_reg;
    logic        cfg_ro_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_size_reg <= RESET_SIZE;
            cfg_ro_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BUFFER_SIZE: cfg_size_reg <= cfg_wr_data;
                CFG_READ_ONLY:   cfg_ro_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic [16:0] size_use;
    assign size_use = (cfg_size_reg > LIMIT17) ? LIMIT17 : cfg_size_reg;

    // control state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [2:0]        pend_idx_reg, pend_idx_next;
    logic              m_valid_reg, m_valid_next;

    // item payload
    logic        write_reg, write_next;
    logic [1:0]  size_reg, size_next;
    logic        sgn_reg, sgn_next;
    logic        little_reg, little_next;
    logic [15:0] off_reg, off_next;
    logic [63:0] wval_reg, wval_next;
    logic [1:0]  status_reg, status_next;
    logic [16:0] next_reg, next_next;
    logic [63:0] rval_reg, rval_next;

    // result register
    logic [63:0] m_read_value_reg, m_read_value_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [16:0] m_next_offset_reg, m_next_offset_next;

    // memory port
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;

    tebac_store #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .rd_en   (mem_re),
        .addr    (mem_addr),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    // input decode
    kind_t       in_kind;
    logic [16:0] in_next;
    logic [1:0]  in_status;

    always_comb begin
        in_kind = decode_type(s_type_code);
        in_next = {1'b0, s_byte_offset};
        if (in_kind.known) begin
            in_next = {1'b0, s_byte_offset} + (17'd1 << in_kind.size);
        end
        if (s_req_type == REQ_WRITE && cfg_ro_reg) begin
            in_status = STATUS_READONLY;
        end else if (!in_kind.known || in_next > size_use) begin
            in_status = STATUS_BOUNDS;
        end else begin
            in_status = STATUS_OK;
        end
    end

    // byte position within the value; big endian mirrors the index
    logic [3:0]  n_bytes;
    logic [2:0]  idx;
    logic [2:0]  mask;
    logic [2:0]  pos;
    logic [16:0] addr17;

    assign n_bytes = 4'd1 << size_reg;
    assign idx     = cnt_reg[2:0];
    assign mask    = 3'(n_bytes - 4'd1);
    assign pos     = little_reg ? idx : (mask ^ idx);
    assign addr17  = {1'b0, off_reg} + 17'(pos);

    // sign extension of the assembled value
    logic [63:0] rval_ext;

    always_comb begin
        rval_ext = rval_reg;
        if (sgn_reg) begin
            case (size_reg)
                2'd0:    rval_ext = {{56{rval_reg[7]}}, rval_reg[7:0]};
                2'd1:    rval_ext = {{48{rval_reg[15]}}, rval_reg[15:0]};
                2'd2:    rval_ext = {{32{rval_reg[31]}}, rval_reg[31:0]};
                default: rval_ext = rval_reg;
            endcase
        end
    end

    always_comb begin
        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        cnt_next           = cnt_reg;
        pend_next          = 1'b0;
        pend_idx_next      = idx;
        m_valid_next       = m_valid_reg;
        write_next         = write_reg;
        size_next          = size_reg;
        sgn_next           = sgn_reg;
        little_next        = little_reg;
        off_next           = off_reg;
        wval_next          = wval_reg;
        status_next        = status_reg;
        next_next          = next_reg;
        rval_next          = rval_reg;
        m_read_value_next  = m_read_value_reg;
        m_status_next      = m_status_reg;
        m_next_offset_next = m_next_offset_reg;

        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = ADDR_W'(addr17);
        mem_wdata = wval_reg[8*idx +: 8];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // read data lands in the cycle after the request
        if (pend_reg) begin
            rval_next[8*pend_idx_reg +: 8] = mem_rdata;
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 8'd0;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    write_next  = (s_req_type == REQ_WRITE);
                    size_next   = in_kind.size;
                    sgn_next    = in_kind.sgn;
                    little_next = in_kind.little;
                    off_next    = s_byte_offset;
                    wval_next   = s_write_value;
                    status_next = in_status;
                    next_next   = in_next;
                    rval_next   = 64'd0;
                    cnt_next    = 4'd0;
                    state_next  = (in_status == STATUS_OK) ? S_WORK : S_FINISH;
                end
            end
            S_WORK: begin
                if (cnt_reg < n_bytes) begin
                    mem_we    = write_reg;
                    mem_re    = !write_reg;
                    pend_next = !write_reg;
                    cnt_next  = cnt_reg + 4'd1;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = status_reg;
                    m_next_offset_next = next_reg;
                    m_read_value_next  = (!write_reg && status_reg == STATUS_OK)
                                         ? rval_ext : 64'd0;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            cnt_reg      <= 4'd0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg      <= pend_idx_next;
        write_reg         <= write_next;
        size_reg          <= size_next;
        sgn_reg           <= sgn_next;
        little_reg        <= little_next;
        off_reg           <= off_next;
        wval_reg          <= wval_next;
        status_reg        <= status_next;
        next_reg          <= next_next;
        rval_reg          <= rval_next;
        m_read_value_reg  <= m_read_value_next;
        m_status_reg      <= m_status_next;
        m_next_offset_reg <= m_next_offset_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_status      = m_status_reg;
    assign m_next_offset = m_next_offset_reg;

endmodule

`default_nettype wire
